// ===== rtl/pbmsd_pkg.sv =====
package pbmsd_pkg;

   localparam int unsigned ACC_W = 64;
   localparam int unsigned CNT_W = 4;
   localparam logic [CNT_W-1:0] VARINT_MAX_BYTES = 4'd10;

   typedef enum logic [7:0] {
      PH_TAG     = 8'b0000_0001,
      PH_VERSION = 8'b0000_0010,
      PH_LEN     = 8'b0000_0100,
      PH_PAYLOAD = 8'b0000_1000,
      PH_SKIPVAR = 8'b0001_0000,
      PH_SKIPLEN = 8'b0010_0000,
      PH_SKIP    = 8'b0100_0000,
      PH_ERROR   = 8'b1000_0000
   } phase_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_TOO_LONG  = 3'd2;
   localparam logic [2:0] ST_ZERO_TAG  = 3'd3;
   localparam logic [2:0] ST_BAD_WIRE  = 3'd4;
   localparam logic [2:0] ST_VER_BIG   = 3'd5;
   localparam logic [2:0] ST_MISSING   = 3'd6;

   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_FIX64  = 3'd1;
   localparam logic [2:0] WT_LEN    = 3'd2;
   localparam logic [2:0] WT_FIX32  = 3'd5;

   localparam logic [60:0] FLD_INDEX   = 61'd1;
   localparam logic [60:0] FLD_VALUE   = 61'd2;
   localparam logic [60:0] FLD_PADDING = 61'd3;
   localparam logic [60:0] FLD_VERSION = 61'd4;

   localparam int unsigned SEEN_INDEX   = 0;
   localparam int unsigned SEEN_VALUE   = 1;
   localparam int unsigned SEEN_PADDING = 2;
   localparam int unsigned SEEN_VERSION = 3;

   typedef struct packed {
      logic [ACC_W-1:0] accum;
      logic [CNT_W-1:0] count;
      logic             done;
      logic             too_long;
   } varint_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic [1:0]  field_select;
      logic        field_start;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] version_out;
      logic        ver_seen;
      logic        pad_seen;
   } result_type;

   function automatic logic [5:0] varint_shamt(input logic [CNT_W-1:0] cnt);
      return 6'(6'(cnt) * 6'd7);
   endfunction

endpackage

// ===== rtl/pbmsd_varint.sv =====
module pbmsd_varint
   import pbmsd_pkg::*;
(
   input  logic [ACC_W-1:0] accum,
   input  logic [CNT_W-1:0] count,
   input  logic [7:0]       in_byte,
   output varint_type       vr
);

   logic [ACC_W-1:0] part;
   logic [CNT_W-1:0] count_inc;

   assign part      = {{(ACC_W-7){1'b0}}, in_byte[6:0]} << varint_shamt(count);
   assign count_inc = count + CNT_W'(1);

   always_comb begin
      vr.accum    = accum | part;
      vr.done     = !in_byte[7];
      vr.count    = in_byte[7] ? count_inc : count;
      vr.too_long = in_byte[7] && (count_inc >= VARINT_MAX_BYTES);
   end

endmodule

// ===== rtl/pbmsd_parser.sv =====
module pbmsd_parser
   import pbmsd_pkg::*;
#(
   parameter int unsigned LEN_BITS = 32
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] in_byte,
   input  logic       is_last,
   output result_type res
);

   phase_type           phase_ff, phase_in, s_phase;
   logic [ACC_W-1:0]    acc_ff, acc_in, s_acc;
   logic [CNT_W-1:0]    cnt_ff, cnt_in, s_cnt;
   logic [1:0]          fld_ff, fld_in, s_fld;
   logic [LEN_BITS-1:0] rem_ff, rem_in, s_rem, rem_dec;
   logic [31:0]         ver_ff, ver_in, s_ver;
   logic [3:0]          seen_ff, seen_in, s_seen;
   logic [2:0]          err_ff, err_in, s_err;
   varint_type          vr;
   logic [60:0]         tag_fld;
   logic [2:0]          tag_wt;
   logic                len_fits;
   logic                bad_end;
   logic [7:0]          o_byte;
   logic                o_valid;
   logic [1:0]          o_sel;
   logic                o_start;
   logic [2:0]          o_status;

   pbmsd_varint u_varint (
      .accum   (acc_ff),
      .count   (cnt_ff),
      .in_byte (in_byte),
      .vr      (vr)
   );

   assign tag_fld  = vr.accum[63:3];
   assign tag_wt   = vr.accum[2:0];
   assign len_fits = ((vr.accum >> LEN_BITS) == '0);
   assign rem_dec  = rem_ff - LEN_BITS'(1);

   always_comb begin
      s_phase = phase_ff;
      s_acc   = acc_ff;
      s_cnt   = cnt_ff;
      s_fld   = fld_ff;
      s_rem   = rem_ff;
      s_ver   = ver_ff;
      s_seen  = seen_ff;
      s_err   = err_ff;
      o_byte  = 8'd0;
      o_valid = 1'b0;
      o_sel   = 2'd0;
      o_start = 1'b0;
      case (phase_ff)
         PH_TAG, PH_VERSION, PH_LEN, PH_SKIPLEN, PH_SKIPVAR: begin
            s_acc = vr.accum;
            s_cnt = vr.count;
            if (vr.too_long) begin
               s_phase = PH_ERROR;
               s_err   = ST_TOO_LONG;
               s_acc   = '0;
               s_cnt   = '0;
            end else if (vr.done) begin
               s_acc = '0;
               s_cnt = '0;
               case (phase_ff)
                  PH_TAG: begin
                     if (vr.accum == '0) begin
                        s_phase = PH_ERROR;
                        s_err   = ST_ZERO_TAG;
                     end else if (tag_fld == FLD_VERSION && tag_wt == WT_VARINT) begin
                        s_phase = PH_VERSION;
                     end else if (tag_fld >= FLD_INDEX && tag_fld <= FLD_PADDING
                                  && tag_wt == WT_LEN) begin
                        s_fld   = tag_fld[1:0] - FLD_INDEX[1:0];
                        s_phase = PH_LEN;
                     end else if (tag_wt == WT_VARINT) begin
                        s_phase = PH_SKIPVAR;
                     end else if (tag_wt == WT_FIX64) begin
                        s_rem   = LEN_BITS'(8);
                        s_phase = PH_SKIP;
                     end else if (tag_wt == WT_LEN) begin
                        s_phase = PH_SKIPLEN;
                     end else if (tag_wt == WT_FIX32) begin
                        s_rem   = LEN_BITS'(4);
                        s_phase = PH_SKIP;
                     end else begin
                        s_phase = PH_ERROR;
                        s_err   = ST_BAD_WIRE;
                     end
                  end
                  PH_VERSION: begin
                     if (vr.accum[63:32] != '0) begin
                        s_phase = PH_ERROR;
                        s_err   = ST_VER_BIG;
                     end else begin
                        s_ver                = vr.accum[31:0];
                        s_seen[SEEN_VERSION] = 1'b1;
                        s_phase              = PH_TAG;
                     end
                  end
                  PH_LEN, PH_SKIPLEN: begin
                     if (!len_fits) begin
                        s_phase = PH_ERROR;
                        s_err   = ST_TRUNCATED;
                     end else begin
                        s_rem = vr.accum[LEN_BITS-1:0];
                        if (phase_ff == PH_LEN) begin
                           o_start        = 1'b1;
                           o_sel          = fld_ff;
                           s_seen[fld_ff] = 1'b1;
                           s_phase = (s_rem != '0) ? PH_PAYLOAD : PH_TAG;
                        end else begin
                           s_phase = (s_rem != '0) ? PH_SKIP : PH_TAG;
                        end
                     end
                  end
                  default: begin
                     s_phase = PH_TAG;
                  end
               endcase
            end
         end
         PH_PAYLOAD: begin
            o_byte  = in_byte;
            o_valid = 1'b1;
            o_sel   = fld_ff;
            s_rem   = rem_dec;
            if (rem_dec == '0) begin
               s_phase = PH_TAG;
            end
         end
         PH_SKIP: begin
            s_rem = rem_dec;
            if (rem_dec == '0) begin
               s_phase = PH_TAG;
            end
         end
         default: begin
         end
      endcase
   end

   assign bad_end = (s_phase != PH_TAG) || (s_cnt != '0);

   always_comb begin
      o_status = ST_OK;
      if (is_last) begin
         if (s_err != ST_OK) begin
            o_status = s_err;
         end else if (bad_end) begin
            o_status = ST_TRUNCATED;
         end else if (!(s_seen[SEEN_INDEX] && s_seen[SEEN_VALUE])) begin
            o_status = ST_MISSING;
         end
      end
   end

   always_comb begin
      res.out_byte     = o_byte;
      res.byte_valid   = o_valid;
      res.field_select = o_sel;
      res.field_start  = o_start;
      res.done_res     = is_last;
      res.status       = o_status;
      res.version_out  = s_ver;
      res.ver_seen     = s_seen[SEEN_VERSION];
      res.pad_seen     = s_seen[SEEN_PADDING];
   end

   always_comb begin
      if (is_last) begin
         phase_in = PH_TAG;
         acc_in   = '0;
         cnt_in   = '0;
         fld_in   = 2'd0;
         rem_in   = '0;
         ver_in   = 32'd0;
         seen_in  = 4'd0;
         err_in   = ST_OK;
      end else begin
         phase_in = s_phase;
         acc_in   = s_acc;
         cnt_in   = s_cnt;
         fld_in   = s_fld;
         rem_in   = s_rem;
         ver_in   = s_ver;
         seen_in  = s_seen;
         err_in   = s_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         fld_ff   <= 2'd0;
         rem_ff   <= '0;
         ver_ff   <= 32'd0;
         seen_ff  <= 4'd0;
         err_ff   <= ST_OK;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         fld_ff   <= fld_in;
         rem_ff   <= rem_in;
         ver_ff   <= ver_in;
         seen_ff  <= seen_in;
         err_ff   <= err_in;
      end
   end

   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK) == (phase_ff == PH_ERROR))
      else $error("Error code and error phase disagree.");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && is_last |=> phase_ff == PH_TAG && seen_ff == 4'd0 && cnt_ff == '0)
      else $error("Parser state not cleared after the last item of a message.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < VARINT_MAX_BYTES)
      else $error("Varint byte count out of range.");

endmodule

// ===== rtl/protobuf_message_stream_decoder_unit.sv =====
// Streaming decoder for one protobuf message format, one encoded byte per item.
// The request channel (req_valid, req_stall, req_in_byte, req_is_last) takes the
// message bytes in order; req_is_last marks the final byte of each message.
// Every request item gives exactly one response item on the rsp_ channel.
// Payload bytes of fields 1, 2 and 3 appear with rsp_byte_valid and their field
// in rsp_field_select; rsp_field_start marks a new occurrence of a field, so the
// consumer drops any earlier copy. The response for the last byte carries
// rsp_done_res and the final status, and the parser then starts a new message.
// A request passes through the input register, then the parse logic, into the
// response register, and the response waits there until the receiver takes it.
// Throughput is one item per cycle while the receiver does not stall, set by the
// parse step and its state feedback. Reset empties both registers and clears all
// parser state. When the receiver stalls, the response register holds its item,
// the input register takes one more, and req_stall is high while both are full.
module protobuf_message_stream_decoder_unit
   import pbmsd_pkg::*;
#(
   parameter int unsigned LEN_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic [1:0]  rsp_field_select,
   output logic        rsp_field_start,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_version_out,
   output logic        rsp_ver_seen,
   output logic        rsp_pad_seen
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type res;
   logic       out_free;
   logic       step;
   logic       accept;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   pbmsd_parser #(
      .LEN_BITS (LEN_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .in_byte (in_byte_ff),
      .is_last (in_last_ff),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_is_last;
      end
      if (step) begin
         out_ff <= res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_ff.out_byte;
   assign rsp_byte_valid   = out_ff.byte_valid;
   assign rsp_field_select = out_ff.field_select;
   assign rsp_field_start  = out_ff.field_start;
   assign rsp_done_res     = out_ff.done_res;
   assign rsp_status       = out_ff.status;
   assign rsp_version_out  = out_ff.version_out;
   assign rsp_ver_seen     = out_ff.ver_seen;
   assign rsp_pad_seen     = out_ff.pad_seen;

   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == ST_OK)
      else $error("Nonzero status on an item that does not end a message.");

   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("Waiting input item lost or changed.");

   a_start_not_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_byte_valid && rsp_field_start))
      else $error("Field start and payload byte on the same item.");

endmodule

// ===== verif/protobuf_message_stream_decoder_checker.sv =====
// Watches both channels of the decoder, predicts one response per accepted byte
// and compares every accepted response with the oldest prediction.
module protobuf_message_stream_decoder_checker
   import pbmsd_pkg::*;
#(
   parameter int unsigned LEN_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_is_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_byte_valid,
   input  logic [1:0]  rsp_field_select,
   input  logic        rsp_field_start,
   input  logic        rsp_done_res,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_version_out,
   input  logic        rsp_ver_seen,
   input  logic        rsp_pad_seen,
   output int          mismatches,
   output int          outstanding
);

   localparam logic [63:0] LEN_LIMIT =
      (LEN_BITS >= 64) ? '1 : ((64'd1 << LEN_BITS) - 64'd1);

   typedef enum logic [1:0] {
      VARINT_PENDING,
      VARINT_COMPLETE,
      VARINT_OVERLONG
   } varint_step_type;

   phase_type   phase;
   logic [63:0] vaccum;
   logic [3:0]  vcount;
   logic [1:0]  cur_field;
   logic [63:0] remaining;
   logic [31:0] cur_version;
   logic [3:0]  seen;
   logic [2:0]  err_code;

   result_type expected_results[$];
   result_type want;
   int         rsp_count;

   function automatic void clear_varint();
      vaccum = '0;
      vcount = '0;
   endfunction

   function automatic void reset_decoder();
      phase = PH_TAG;
      clear_varint();
      cur_field = '0;
      remaining = '0;
      cur_version = '0;
      seen = '0;
      err_code = ST_OK;
   endfunction

   function automatic void raise_error(input logic [2:0] code);
      if (err_code == ST_OK) begin
         err_code = code;
      end
      phase = PH_ERROR;
      clear_varint();
   endfunction

   function automatic varint_step_type feed_varint(input logic [7:0] b);
      int unsigned shift;
      shift = 7 * vcount;
      if (shift <= 63) begin
         vaccum = vaccum | (64'(b[6:0]) << shift);
      end
      if (!b[7]) begin
         return VARINT_COMPLETE;
      end
      vcount = vcount + 4'd1;
      if (vcount >= VARINT_MAX_BYTES) begin
         return VARINT_OVERLONG;
      end
      return VARINT_PENDING;
   endfunction

   function automatic result_type decode_byte(input logic [7:0] b, input logic last);
      result_type      r;
      varint_step_type vs;
      logic [63:0]     tag;
      logic [63:0]     fld;
      logic [2:0]      wt;
      r = '0;
      case (phase)
         PH_TAG: begin
            vs = feed_varint(b);
            if (vs == VARINT_OVERLONG) begin
               raise_error(ST_TOO_LONG);
            end else if (vs == VARINT_COMPLETE) begin
               tag = vaccum;
               fld = tag >> 3;
               wt = tag[2:0];
               clear_varint();
               if (tag == 64'd0) begin
                  raise_error(ST_ZERO_TAG);
               end else if (fld == 64'(FLD_VERSION) && wt == WT_VARINT) begin
                  phase = PH_VERSION;
               end else if (fld >= 64'(FLD_INDEX) && fld <= 64'(FLD_PADDING)
                            && wt == WT_LEN) begin
                  cur_field = 2'(fld - 64'(FLD_INDEX));
                  phase = PH_LEN;
               end else if (wt == WT_VARINT) begin
                  phase = PH_SKIPVAR;
               end else if (wt == WT_FIX64) begin
                  remaining = 64'd8;
                  phase = PH_SKIP;
               end else if (wt == WT_LEN) begin
                  phase = PH_SKIPLEN;
               end else if (wt == WT_FIX32) begin
                  remaining = 64'd4;
                  phase = PH_SKIP;
               end else begin
                  raise_error(ST_BAD_WIRE);
               end
            end
         end
         PH_VERSION: begin
            vs = feed_varint(b);
            if (vs == VARINT_OVERLONG) begin
               raise_error(ST_TOO_LONG);
            end else if (vs == VARINT_COMPLETE) begin
               if (vaccum > 64'hffff_ffff) begin
                  raise_error(ST_VER_BIG);
               end else begin
                  cur_version = vaccum[31:0];
                  seen[SEEN_VERSION] = 1'b1;
                  clear_varint();
                  phase = PH_TAG;
               end
            end
         end
         PH_LEN, PH_SKIPLEN: begin
            vs = feed_varint(b);
            if (vs == VARINT_OVERLONG) begin
               raise_error(ST_TOO_LONG);
            end else if (vs == VARINT_COMPLETE) begin
               if (vaccum > LEN_LIMIT) begin
                  raise_error(ST_TRUNCATED);
               end else begin
                  remaining = vaccum;
                  clear_varint();
                  if (phase == PH_LEN) begin
                     r.field_start = 1'b1;
                     r.field_select = cur_field;
                     seen[cur_field] = 1'b1;
                     phase = (remaining != 0) ? PH_PAYLOAD : PH_TAG;
                  end else begin
                     phase = (remaining != 0) ? PH_SKIP : PH_TAG;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            r.out_byte = b;
            r.byte_valid = 1'b1;
            r.field_select = cur_field;
            remaining = remaining - 64'd1;
            if (remaining == 0) begin
               phase = PH_TAG;
            end
         end
         PH_SKIPVAR: begin
            vs = feed_varint(b);
            if (vs == VARINT_OVERLONG) begin
               raise_error(ST_TOO_LONG);
            end else if (vs == VARINT_COMPLETE) begin
               clear_varint();
               phase = PH_TAG;
            end
         end
         PH_SKIP: begin
            remaining = remaining - 64'd1;
            if (remaining == 0) begin
               phase = PH_TAG;
            end
         end
         default: begin
         end
      endcase
      r.done_res = last;
      r.version_out = cur_version;
      r.ver_seen = seen[SEEN_VERSION];
      r.pad_seen = seen[SEEN_PADDING];
      if (last) begin
         if (err_code != ST_OK) begin
            r.status = err_code;
         end else if (phase != PH_TAG || vcount != 0) begin
            r.status = ST_TRUNCATED;
         end else if (!(seen[SEEN_INDEX] && seen[SEEN_VALUE])) begin
            r.status = ST_MISSING;
         end else begin
            r.status = ST_OK;
         end
         reset_decoder();
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (exp_val !== got_val) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch in %s of response %0d: expected 0x%0h, got 0x%0h",
                     name, rsp_count, exp_val, got_val);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_decoder();
         expected_results.delete();
         mismatches = 0;
         rsp_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Response %0d arrived with no item waiting for it", rsp_count);
               end
            end else begin
               want = expected_results.pop_front();
               check_field("out_byte", 32'(want.out_byte), 32'(rsp_out_byte));
               check_field("byte_valid", 32'(want.byte_valid), 32'(rsp_byte_valid));
               check_field("field_select", 32'(want.field_select), 32'(rsp_field_select));
               check_field("field_start", 32'(want.field_start), 32'(rsp_field_start));
               check_field("done_res", 32'(want.done_res), 32'(rsp_done_res));
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("version_out", want.version_out, rsp_version_out);
               check_field("ver_seen", 32'(want.ver_seen), 32'(rsp_ver_seen));
               check_field("pad_seen", 32'(want.pad_seen), 32'(rsp_pad_seen));
            end
            rsp_count++;
         end
         if (req_valid && !req_stall) begin
            expected_results.insert(expected_results.size(),
                                    decode_byte(req_in_byte, req_is_last));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// ===== verif/tb.sv =====
module tb
   import pbmsd_pkg::*;
();

   localparam int unsigned LEN_BITS     = 32;
   localparam int          RANDOM_BYTES = 1500;
   localparam int          CYCLE_LIMIT  = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_is_last;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic [1:0]  rsp_field_select;
   logic        rsp_field_start;
   logic        rsp_done_res;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_version_out;
   logic        rsp_ver_seen;
   logic        rsp_pad_seen;

   int         mismatches;
   int         outstanding;
   logic [7:0] msg_q[$];
   int         sent_count = 0;
   int         msg_count = 0;
   int         cycle_count = 0;
   logic       req_quiet = 1'b0;
   logic       rsp_quiet = 1'b0;
   int         rsp_hold = 0;
   int         rsp_wait;

   protobuf_message_stream_decoder_unit #(
      .LEN_BITS(LEN_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_field_select(rsp_field_select),
      .rsp_field_start(rsp_field_start),
      .rsp_done_res(rsp_done_res),
      .rsp_status(rsp_status),
      .rsp_version_out(rsp_version_out),
      .rsp_ver_seen(rsp_ver_seen),
      .rsp_pad_seen(rsp_pad_seen)
   );

   protobuf_message_stream_decoder_checker #(
      .LEN_BITS(LEN_BITS)
   ) u_chk (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_field_select(rsp_field_select),
      .rsp_field_start(rsp_field_start),
      .rsp_done_res(rsp_done_res),
      .rsp_status(rsp_status),
      .rsp_version_out(rsp_version_out),
      .rsp_ver_seen(rsp_ver_seen),
      .rsp_pad_seen(rsp_pad_seen),
      .mismatches(mismatches),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // The receiver stalls for a random number of cycles after each item it takes,
   // except during quiet stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
         rsp_quiet <= 1'b0;
      end else begin
         if ($urandom_range(0, 299) == 0) begin
            rsp_quiet <= !rsp_quiet;
         end
         if (rsp_stall) begin
            if (rsp_hold <= 1) begin
               rsp_stall <= 1'b0;
            end
            rsp_hold <= rsp_hold - 1;
         end else if (rsp_valid) begin
            rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 6);
            if (rsp_wait != 0) begin
               rsp_stall <= 1'b1;
               rsp_hold <= rsp_wait;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_is_last <= last;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      sent_count++;
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_q.size(); i++) begin
         send_byte(msg_q[i], i == msg_q.size() - 1);
      end
      msg_q.delete();
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand_wide();
      logic [63:0] v;
      int          bits;
      v = {$urandom, $urandom};
      bits = $urandom_range(0, 64);
      if (bits < 64) begin
         v = v & ((64'd1 << bits) - 64'd1);
      end
      return v;
   endfunction

   function automatic int rand_pad();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   function automatic int pick_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
   endfunction

   task automatic add_byte(input logic [7:0] b);
      msg_q.insert(msg_q.size(), b);
   endtask

   // A nonzero pad stretches the varint with redundant continuation bytes.
   task automatic add_varint(input logic [63:0] v, input int pad);
      int          n;
      int          total;
      logic [63:0] rest;
      n = 1;
      rest = v >> 7;
      while (rest != 0) begin
         n++;
         rest = rest >> 7;
      end
      total = (n + pad > 10) ? 10 : n + pad;
      for (int i = 0; i < total; i++) begin
         add_byte({i < total - 1, 7'(v >> (7 * i))});
      end
   endtask

   task automatic add_tag(input logic [63:0] fld, input logic [2:0] wt);
      add_varint((fld << 3) | 64'(wt), rand_pad());
   endtask

   task automatic add_random_bytes(input int count);
      repeat (count) add_byte(8'($urandom));
   endtask

   task automatic add_bytes_field(input logic [63:0] fld, input int len);
      add_tag(fld, WT_LEN);
      add_varint(64'(len), rand_pad());
      add_random_bytes(len);
   endtask

   task automatic add_version();
      logic [63:0] v;
      case ($urandom_range(0, 3))
         0: v = 64'd0;
         1: v = 64'($urandom_range(1, 300));
         2: v = 64'($urandom);
         default: v = 64'hffff_ffff;
      endcase
      add_tag(64'(FLD_VERSION), WT_VARINT);
      add_varint(v, rand_pad());
   endtask

   task automatic add_unknown_field();
      logic [63:0] fld;
      logic [2:0]  wt;
      int          len;
      case ($urandom_range(0, 2))
         0: fld = 64'($urandom_range(1, 4));
         1: fld = 64'($urandom_range(5, 30));
         default: fld = {$urandom, $urandom} >> 3;
      endcase
      if (fld == 0) begin
         fld = 64'd5;
      end
      case ($urandom_range(0, 3))
         0: wt = WT_VARINT;
         1: wt = WT_FIX64;
         2: wt = WT_LEN;
         default: wt = WT_FIX32;
      endcase
      add_tag(fld, wt);
      if (wt == WT_VARINT) begin
         add_varint(rand_wide(), rand_pad());
      end else if (wt == WT_FIX64) begin
         add_random_bytes(8);
      end else if (wt == WT_FIX32) begin
         add_random_bytes(4);
      end else begin
         len = pick_len();
         add_varint(64'(len), rand_pad());
         add_random_bytes(len);
      end
   endtask

   task automatic build_message();
      int n_fields;
      n_fields = $urandom_range(0, 5);
      for (int i = 0; i < n_fields; i++) begin
         case ($urandom_range(0, 5))
            0: add_bytes_field(64'(FLD_INDEX), pick_len());
            1: add_bytes_field(64'(FLD_VALUE), pick_len());
            2: add_bytes_field(64'(FLD_PADDING), pick_len());
            3: add_version();
            default: add_unknown_field();
         endcase
      end
      if ($urandom_range(0, 9) != 0) begin
         add_bytes_field(64'(FLD_INDEX), pick_len());
      end
      if ($urandom_range(0, 9) != 0) begin
         add_bytes_field(64'(FLD_VALUE), pick_len());
      end
      if (msg_q.size() == 0) begin
         add_version();
      end
   endtask

   task automatic corrupt_message();
      int keep;
      case ($urandom_range(0, 7))
         0: begin
            if (msg_q.size() > 1) begin
               keep = $urandom_range(1, msg_q.size() - 1);
               while (msg_q.size() > keep) void'(msg_q.pop_back());
            end
         end
         1: begin
            repeat (10) add_byte({1'b1, 7'($urandom)});
            add_random_bytes($urandom_range(0, 4));
         end
         2: begin
            add_varint(64'd0, rand_pad());
            add_random_bytes($urandom_range(0, 4));
         end
         3: begin
            case ($urandom_range(0, 3))
               0: add_tag(64'($urandom_range(1, 40)), 3'd3);
               1: add_tag(64'($urandom_range(1, 40)), 3'd4);
               2: add_tag(64'($urandom_range(1, 40)), 3'd6);
               default: add_tag(64'($urandom_range(1, 40)), 3'd7);
            endcase
            add_random_bytes($urandom_range(0, 4));
         end
         4: begin
            add_tag(64'(FLD_VERSION), WT_VARINT);
            add_varint(rand_wide() | (64'd1 << $urandom_range(32, 63)), 0);
            add_random_bytes($urandom_range(0, 3));
         end
         5: begin
            add_tag(64'($urandom_range(1, 10)), WT_LEN);
            add_varint(rand_wide() | (64'd1 << $urandom_range(32, 63)), 0);
            add_random_bytes($urandom_range(0, 3));
         end
         6: begin
            add_random_bytes($urandom_range(1, 8));
         end
         default: begin
            // Ten-byte index tag whose last byte carries bits beyond the 64-bit value.
            add_byte(8'h8a);
            repeat (8) add_byte(8'h80);
            add_byte({1'b0, 6'($urandom), 1'b0});
            keep = $urandom_range(0, 3);
            add_varint(64'(keep), 0);
            add_random_bytes(keep);
         end
      endcase
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      req_is_last = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      msg_q = '{8'h0a, 8'h00, 8'h12, 8'h00};
      send_message();
      msg_q = '{8'h00};
      send_message();
      msg_q = '{8'h0b};
      send_message();
      msg_q = '{8'h0a};
      send_message();
      msg_q = '{8'h20, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
      send_message();
      msg_q = '{8'h0a, 8'h01, 8'hff};
      send_message();
      msg_q = '{8'h20, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'h0a, 8'h00, 8'h12, 8'h00};
      send_message();
      msg_q = '{8'h1a, 8'h01, 8'h55, 8'h0a, 8'h01, 8'haa, 8'h12, 8'h00};
      send_message();
      wait_for_idle();

      while (sent_count < RANDOM_BYTES) begin
         build_message();
         if ($urandom_range(0, 3) == 0) begin
            corrupt_message();
         end
         req_quiet = ($urandom_range(0, 4) == 0);
         send_message();
         msg_count++;
         if (msg_count % 25 == 0) begin
            wait_for_idle();
         end
      end
      req_valid <= 1'b0;

      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== protobuf_message_stream_decoder_unit.f =====
rtl/pbmsd_pkg.sv
rtl/pbmsd_varint.sv
rtl/pbmsd_parser.sv
rtl/protobuf_message_stream_decoder_unit.sv
verif/protobuf_message_stream_decoder_checker.sv
verif/tb.sv
